// ===== rtl/core/ndvi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ndvi_pkg;

    // Item field widths
    localparam int IDX_W       = 8;
    localparam int IN_VALUE_W  = 32;
    localparam int DIFF_W      = 33;
    localparam int CFG_COUNT_W = 9;

    // Parameter defaults
    localparam int DEF_MAX_BINS   = 256;
    localparam int DEF_VALUE_BITS = 32;

    // Result when no bin differs
    localparam logic [DIFF_W-1:0] DIFF_NONE = {DIFF_W{1'b1}};

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register port
    localparam int                    APB_ADDR_W      = 3;
    localparam int                    APB_DATA_W      = 32;
    localparam logic [APB_ADDR_W-1:0] REG_BIN_COUNT   = 3'h0;
    localparam logic [CFG_COUNT_W-1:0] BIN_COUNT_RESET = 9'd256;

    // Controller to datapath
    typedef struct packed {
        logic load;      // write the input value into its bin
        logic start;     // latch query bin and count, clear best
        logic sel_self;  // read address is the query bin
        logic take_self; // capture the query bin's value
        logic issue;     // read next scan address
        logic emit;      // load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic query_ok;  // query bin lies below the effective count
        logic more;      // scan addresses remain
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/ndvi_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ndvi_in_if
    import ndvi_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [IDX_W-1:0]             bin_index;
    logic signed [IN_VALUE_W-1:0] value;

    modport source (output valid, output mode, output bin_index, output value,
                    input ready);
    modport sink   (input valid, input mode, input bin_index, input value,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ndvi_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ndvi_out_if
    import ndvi_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIFF_W-1:0] difference;
    logic              found;

    modport source (output valid, output nearest_index, output difference,
                    output found, input ready);
    modport sink   (input valid, input nearest_index, input difference,
                    input found, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ndvi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndvi_ctrl
    import ndvi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_mode,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELF,
        ST_GRAB,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_sts.query_ok ? ST_SELF : ST_FINISH;
                    end
                end
            end
            ST_SELF: begin
                o_cmd.sel_self = 1'b1;
                n_state        = ST_GRAB;
            end
            ST_GRAB: begin
                o_cmd.take_self = 1'b1;
                o_cmd.issue     = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.more) begin
                    o_cmd.issue = 1'b1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/ndvi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndvi_dp
    import ndvi_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_sts                           o_sts,
    input  wire logic [IDX_W-1:0]             i_bin_index,
    input  wire logic signed [IN_VALUE_W-1:0] i_value,
    input  wire logic [CFG_COUNT_W-1:0]       i_bin_count,
    output logic [IDX_W-1:0]                  o_nearest_index,
    output logic [DIFF_W-1:0]                 o_difference,
    output logic                              o_found
);

    localparam int AW    = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
    localparam int XW    = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

    // store, values biased so unsigned order is signed order
    logic [VALUE_BITS-1:0] r_mem [MAX_BINS];
    logic [VALUE_BITS-1:0] r_rd_data;

    logic [AW-1:0]         r_self_idx;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_addr;
    logic [AW-1:0]         r_cmp_idx;
    logic                  r_cmp_vld;
    logic [VALUE_BITS-1:0] r_self;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_best_d;
    logic [AW-1:0]         r_best_idx;
    logic [AW-1:0]         r_best_off;
    logic [IDX_W-1:0]      r_out_index;
    logic [DIFF_W-1:0]     r_out_diff;
    logic                  r_out_found;

    logic [CMP_W-1:0]      w_cnt_ext;
    logic [CMP_W-1:0]      w_cnt_sat;
    logic [CNT_W-1:0]      w_eff_count;
    logic signed [XW-1:0]  w_x;
    logic [VALUE_BITS-1:0] w_biased;
    logic                  w_load_ok;
    logic [AW-1:0]         w_rd_addr;
    logic [VALUE_BITS:0]   w_sub;
    logic [VALUE_BITS-1:0] w_d;
    logic [AW-1:0]         w_off;
    logic                  w_take;
    logic                  w_tie;

    // count saturates at the store depth
    assign w_cnt_ext   = CMP_W'(i_bin_count);
    assign w_cnt_sat   = (w_cnt_ext < CMP_W'(MAX_BINS)) ? w_cnt_ext : CMP_W'(MAX_BINS);
    assign w_eff_count = CNT_W'(w_cnt_sat);

    assign o_sts.query_ok = CMP_W'(i_bin_index) < w_cnt_sat;
    assign o_sts.more     = r_addr < r_count;

    assign w_x       = XW'(i_value);
    assign w_biased  = {~w_x[VALUE_BITS-1], w_x[VALUE_BITS-2:0]};
    assign w_load_ok = CMP_W'(i_bin_index) < CMP_W'(MAX_BINS);
    assign w_rd_addr = i_cmd.sel_self ? r_self_idx : r_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_mem[AW'(i_bin_index)] <= w_biased;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // distance of the bin in flight to the query bin
    assign w_sub = {1'b0, r_rd_data} - {1'b0, r_self};
    assign w_d   = w_sub[VALUE_BITS] ? (VALUE_BITS)'(-w_sub[VALUE_BITS-1:0])
                                     : w_sub[VALUE_BITS-1:0];
    assign w_off = (r_cmp_idx > r_self_idx) ? (r_cmp_idx - r_self_idx)
                                            : (r_self_idx - r_cmp_idx);
    assign w_take = (w_d != '0) && (!r_found || (w_d < r_best_d));
    assign w_tie  = (w_d != '0) && r_found && (w_d == r_best_d) && (w_off <= r_best_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_addr    <= '0;
            r_count   <= '0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_addr  <= '0;
                r_count <= w_eff_count;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_addr <= r_addr + CNT_W'(1);
                end
                if (r_cmp_vld && w_take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_self_idx <= AW'(i_bin_index);
        end
        if (i_cmd.take_self) begin
            r_self <= r_rd_data;
        end
        if (i_cmd.issue) begin
            r_cmp_idx <= r_addr[AW-1:0];
        end
        if (r_cmp_vld && w_take) begin
            r_best_d   <= w_d;
            r_best_idx <= r_cmp_idx;
            r_best_off <= w_off;
        end else if (r_cmp_vld && w_tie) begin
            r_best_idx <= r_cmp_idx;
            r_best_off <= w_off;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_found;
            r_out_index <= r_found ? IDX_W'(r_best_idx) : '0;
            r_out_diff  <= r_found ? DIFF_W'(r_best_d) : DIFF_NONE;
        end
    end

    assign o_nearest_index = r_out_index;
    assign o_difference    = r_out_diff;
    assign o_found         = r_out_found;

endmodule

`default_nettype wire

// ===== rtl/core/nearest_distinct_value_index.sv =====
// A load writes its bin on acceptance. A query reads its own bin, scans bins 0..N-1 with
//   N = min(bin_count, MAX_BINS), then loads the result register; a query bin at or above N
//   skips the reads. One load per cycle while idle; no item is taken until a query is done,
//   the single read port walking one bin per cycle; a waiting result delays the end.
// Reset (i_rst_n, synchronous, active low) clears control and sets bin_count to 256;
//   bin values stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module nearest_distinct_value_index
    import ndvi_pkg::*;
#(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ndvi_in_if.sink                    i_in,
    ndvi_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    t_dp_cmd                w_cmd;
    t_dp_sts                w_sts;
    logic [CFG_COUNT_W-1:0] r_bin_count;

    // Register port: single register, zero wait states.
    // Writes land in the access phase; the block is idle by contract.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count <= BIN_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_BIN_COUNT)) begin
            r_bin_count <= pwdata[CFG_COUNT_W-1:0];
        end
    end

    // unmapped addresses read as zero
    assign prdata = (paddr == REG_BIN_COUNT) ? APB_DATA_W'(r_bin_count) : '0;

    // Controller: accepts items in idle, sequences read of the query bin,
    // the scan over bins 0..count-1 and the hand-off into the result register.
    ndvi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: bin store, one shared subtract/compare unit, best-so-far
    // registers (ties to nearer index, equal distance to later bin) and result.
    ndvi_dp #(
        .MAX_BINS   (MAX_BINS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_bin_index     (i_in.bin_index),
        .i_value         (i_in.value),
        .i_bin_count     (r_bin_count),
        .o_nearest_index (o_out.nearest_index),
        .o_difference    (o_out.difference),
        .o_found         (o_out.found)
    );

endmodule

`default_nettype wire

// ===== tb/tb_nearest_distinct_value_index.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the nearest distinct value search.
// A short table of hand-picked items runs first, then phases of random
// loads and queries, each phase under its own bin count.
module tb_nearest_distinct_value_index;
    import ndvi_pkg::*;

    localparam int  HALF_PERIOD  = 4;
    localparam int  LIMIT_CYCLES = 1_000_000;
    localparam int  SETTLE       = 8;               // margin after the last item
    localparam int  DRAIN        = DEF_MAX_BINS + 8; // longest scan plus pipeline
    localparam int  HOLD_CYCLES  = 400;
    localparam int  N_PLAN       = 24;
    localparam int  N_PHASES     = 12;
    localparam int  SPAN_SMALL   = -1;               // random count 1..40
    localparam int  SPAN_OVER    = -2;               // random count above MAX_BINS
    localparam int  HOLD_PHASE   = 7;

    // Bin count and length of each random phase. Most phases use short scans;
    // the large ones, 511, 256 and SPAN_OVER, scan every bin of the store.
    localparam int PHASE_SPAN  [N_PHASES] = '{1, 0, 2, 511, 256, 3, 5, 8, 16, 33,
                                              SPAN_SMALL, SPAN_OVER};
    localparam int PHASE_ITEMS [N_PHASES] = '{60, 40, 100, 360, 60, 100, 100, 100, 100,
                                              80, 80, 40};

    typedef struct packed {
        logic [IDX_W-1:0]  nearest;
        logic [DIFF_W-1:0] diff;
        logic              found;
    } t_nearest;

    typedef struct packed {
        logic                  mode;
        logic [IDX_W-1:0]      bin;
        logic [IN_VALUE_W-1:0] value;
        logic                  typed;  // want holds a hand-worked answer
        t_nearest              want;
    } t_plan_row;

    localparam t_nearest NO_MATCH = '{nearest: '0, diff: DIFF_NONE, found: 1'b0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ndvi_in_if  in_ch ();
    ndvi_out_if out_ch ();

    nearest_distinct_value_index dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block: bin values, which bins hold a loaded value,
    // and the bin count register.
    logic [IN_VALUE_W-1:0]  bin_value  [DEF_MAX_BINS];
    logic                   bin_loaded [DEF_MAX_BINS];
    logic [CFG_COUNT_W-1:0] scan_count;
    logic [IN_VALUE_W-1:0]  value_pool [4];

    t_nearest pending_nearest [$];   // answers owed by the block, oldest first

    int err_count     = 0;
    int cycles        = 0;
    int burst_left    = 0;
    int hold_requests = 0;

    t_plan_row plan [N_PLAN];

    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_nearest_distinct_value_index: FAIL");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // Expected answer for a query of one bin under the current bin count.
    // Zero differences are skipped; ties go to the smaller index distance,
    // and on equal distance the later bin wins.
    function automatic t_nearest find_nearest(input logic [IDX_W-1:0] bin);
        t_nearest best;
        longint   self_v;
        longint   d;
        longint   best_d;
        int       span;
        int       off;
        int       best_off;
        span     = (int'(scan_count) > DEF_MAX_BINS) ? DEF_MAX_BINS : int'(scan_count);
        best     = NO_MATCH;
        best_d   = 0;
        best_off = 0;
        if (int'(bin) < span) begin
            self_v = longint'($signed(bin_value[bin]));
            for (int j = 0; j < span; j++) begin
                d   = longint'($signed(bin_value[j])) - self_v;
                d   = (d < 0) ? -d : d;
                off = j - int'(bin);
                off = (off < 0) ? -off : off;
                if (d == 0)
                    continue;
                if (!best.found || d < best_d) begin
                    best.found   = 1'b1;
                    best.nearest = IDX_W'(j);
                    best_d       = d;
                    best_off     = off;
                end else if (d == best_d && off <= best_off) begin
                    best.nearest = IDX_W'(j);
                    best_off     = off;
                end
            end
        end
        if (best.found)
            best.diff = DIFF_W'(best_d);
        return best;
    endfunction

    // Bias towards repeats and extremes so that ties and equal bins turn up.
    function automatic logic [IN_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1: return IN_VALUE_W'(int'($urandom_range(0, 8)) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            3:       return value_pool[$urandom_range(0, 3)];
            default: return IN_VALUE_W'($urandom);
        endcase
    endfunction

    task automatic apb_read(output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_BIN_COUNT;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the bin count (upper data bits random, the register keeps 9 bits),
    // then read it back.
    task automatic set_bin_count(input int count);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] wr;
        wr = $urandom;
        wr[CFG_COUNT_W-1:0] = CFG_COUNT_W'(count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BIN_COUNT;
        pwdata  <= wr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        scan_count = wr[CFG_COUNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        apb_read(rd);
        if (rd[CFG_COUNT_W-1:0] !== scan_count)
            report($sformatf("bin_count read %0d, wrote %0d", rd[CFG_COUNT_W-1:0],
                             scan_count));
    endtask

    // Offer one item, inside a burst or after a gap, and update the shadow
    // once it is taken.
    task automatic offer_item(input logic mode, input logic [IDX_W-1:0] bin,
                              input logic [IN_VALUE_W-1:0] value,
                              input logic typed, input t_nearest want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(0, 4);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.bin_index <= bin;
        in_ch.value     <= value;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        burst_left--;
        if (mode == MODE_LOAD) begin
            bin_value[bin]  = value;
            bin_loaded[bin] = 1'b1;
        end else begin
            pending_nearest = {pending_nearest, (typed ? want : find_nearest(bin))};
        end
    endtask

    // Stop offering and wait until the block is idle again.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Result side: checks each taken item, and drives ready on a stall
    // pattern that changes every so often. A requested hold keeps ready low
    // long enough for the block to back up into its input.
    initial begin
        t_nearest got;
        t_nearest want;
        int       stall_pct;
        int       pattern_left;
        int       hold_left;
        int       hold_served;
        stall_pct    = 0;
        pattern_left = 0;
        hold_left    = 0;
        hold_served  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{nearest: out_ch.nearest_index, diff: out_ch.difference,
                        found: out_ch.found};
                if (pending_nearest.size() == 0) begin
                    report($sformatf("result with nothing pending: idx %0d diff %0h",
                                     got.nearest, got.diff));
                end else begin
                    want = pending_nearest.pop_front();
                    if (got.found !== want.found)
                        report($sformatf("found %b, want %b", got.found, want.found));
                    if (got.nearest !== want.nearest)
                        report($sformatf("nearest_index %0d, want %0d",
                                         got.nearest, want.nearest));
                    if (got.diff !== want.diff)
                        report($sformatf("difference %0h, want %0h", got.diff, want.diff));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (pattern_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Stimulus
    initial begin
        logic [APB_DATA_W-1:0] rd;
        logic                  mode;
        logic [IDX_W-1:0]      bin;
        logic [IN_VALUE_W-1:0] value;
        int                    span;
        int                    reach;
        int                    filled;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_LOAD;
        in_ch.bin_index <= '0;
        in_ch.value     <= '0;
        for (int k = 0; k < DEF_MAX_BINS; k++) begin
            bin_value[k]  = '0;
            bin_loaded[k] = 1'b0;
        end
        scan_count = BIN_COUNT_RESET;
        filled     = 0;

        // Hand-picked items, all under a bin count of four. Queries carry junk
        // in the value field, which they must ignore.
        plan = '{
            // four equal bins: nothing differs
            '{MODE_LOAD,  8'd0,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd1,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd2,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd3,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_QUERY, 8'd0,   32'hDEAD_BEEF, 1'b1, NO_MATCH},
            // query bins at and far past the count
            '{MODE_QUERY, 8'd4,   32'h0000_0000, 1'b1, NO_MATCH},
            '{MODE_QUERY, 8'd255, 32'hFFFF_FFFF, 1'b1, NO_MATCH},
            // most negative and most positive values
            '{MODE_LOAD,  8'd1,   32'h8000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd2,   32'h7FFF_FFFF, 1'b0, NO_MATCH},
            // bins 0 and 3 tie on 2^31, bin 0 is closer
            '{MODE_QUERY, 8'd1,   32'h1234_5678, 1'b1, '{8'd0, 33'h0_8000_0000, 1'b1}},
            '{MODE_QUERY, 8'd2,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_QUERY, 8'd0,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd0,   32'd10,        1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd1,   32'd20,        1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd2,   32'd30,        1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd3,   32'd20,        1'b0, NO_MATCH},
            // equal difference and equal distance: the later bin wins
            '{MODE_QUERY, 8'd1,   32'h0000_0000, 1'b1, '{8'd2, 33'd10, 1'b1}},
            '{MODE_QUERY, 8'd3,   32'h0000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd0,   32'h8000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd1,   32'h8000_0000, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd2,   32'h7FFF_FFFF, 1'b0, NO_MATCH},
            '{MODE_LOAD,  8'd3,   32'h8000_0000, 1'b0, NO_MATCH},
            // widest difference, bins 1 and 3 equally close
            '{MODE_QUERY, 8'd2,   32'h0000_0000, 1'b1, '{8'd3, 33'h0_FFFF_FFFF, 1'b1}},
            '{MODE_QUERY, 8'd0,   32'h0000_0000, 1'b0, NO_MATCH}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_read(rd);
        if (rd[CFG_COUNT_W-1:0] !== BIN_COUNT_RESET)
            report($sformatf("bin_count after reset %0d", rd[CFG_COUNT_W-1:0]));

        set_bin_count(4);
        foreach (plan[r])
            offer_item(plan[r].mode, plan[r].bin, plan[r].value, plan[r].typed,
                       plan[r].want);

        // Random phases. Before any query may read the store, every bin below
        // the effective count is loaded, so no unwritten entry is ever scanned.
        for (int p = 0; p < N_PHASES; p++) begin
            case (PHASE_SPAN[p])
                SPAN_SMALL: span = $urandom_range(1, 40);
                SPAN_OVER:  span = $urandom_range(DEF_MAX_BINS + 1, 511);
                default:    span = PHASE_SPAN[p];
            endcase
            settle();
            set_bin_count(span);
            reach = (span > DEF_MAX_BINS) ? DEF_MAX_BINS : span;
            foreach (value_pool[k])
                value_pool[k] = $urandom;
            // long receiver hold while the sender keeps offering
            if (p == HOLD_PHASE)
                hold_requests++;

            repeat (PHASE_ITEMS[p]) begin
                while (filled < DEF_MAX_BINS && bin_loaded[filled])
                    filled++;
                if (filled < reach) begin
                    mode  = MODE_LOAD;
                    bin   = IDX_W'(filled);
                    value = pick_value();
                end else begin
                    mode  = $urandom_range(0, 1) ? MODE_QUERY : MODE_LOAD;
                    // now and then any bin, past the count where it is short
                    bin   = (reach == 0 || $urandom_range(0, 7) == 0)
                            ? IDX_W'($urandom_range(0, DEF_MAX_BINS - 1))
                            : IDX_W'($urandom_range(0, reach - 1));
                    value = (mode == MODE_LOAD) ? pick_value() : IN_VALUE_W'($urandom);
                end
                offer_item(mode, bin, value, 1'b0, NO_MATCH);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_nearest_distinct_value_index: PASS");
        end else begin
            $display("tb_nearest_distinct_value_index: FAIL");
        end
        $finish;
    end

endmodule

// ===== nearest_distinct_value_index.f =====
rtl/core/ndvi_pkg.sv
rtl/core/ndvi_in_if.sv
rtl/core/ndvi_out_if.sv
rtl/core/ndvi_ctrl.sv
rtl/core/ndvi_dp.sv
rtl/core/nearest_distinct_value_index.sv
tb/tb_nearest_distinct_value_index.sv
